// File: hw/rtl/lps_pkg.sv
// ============================================================================
// lps_pkg: shared definitions for the line point stepper
// Default coordinate width and the input operation codes.
// ============================================================================
package lps_pkg;

	localparam int COORD_BITS_DEF = 12;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} lps_op_t;

endpackage

// File: hw/rtl/line_point_stepper.sv
// ============================================================================
// line_point_stepper: integer line rasterizer, one point per beat
// A load beat sets up a line and returns its first point; each step beat
// returns the next point and flags the final one, or point_valid low once the line is done.
// ============================================================================
//
//  channel  dir  tdata (low bit up)                  tuser      tlast
//  s_axis   in   start_x, start_y, end_x, end_y      opcode     -
//  m_axis   out  point_x, point_y                    point_valid point_last
//
// Cycles: every accepted beat yields one result beat, held in the result
//   register; one beat per clock sustained while m_axis_tready is high. The
//   path is one error add and compare in lps_core feeding the result register.
// Reset: arst_n clears the line state and empties the result register.
// Stalls: s_axis_tready drops only while a result is held and m_axis_tready
//   is low; a held result is taken and replaced in the same cycle.
//
module line_point_stepper #(
	parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// start_x, start_y, end_x, end_y, zero fill
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
	// opcode
	input  logic [0:0]                              s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// point_x, point_y, zero fill
	output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
	// point_valid
	output logic [0:0]                              m_axis_tuser,
	// point_last
	output logic                                    m_axis_tlast
);
	import lps_pkg::*;

	localparam int C = COORD_BITS;

	logic                in_beat;
	logic                pt_valid, pt_last;
	logic signed [C-1:0] pt_x, pt_y;

	logic                out_valid_q;
	logic                pt_valid_q, pt_last_q;
	logic signed [C-1:0] pt_x_q, pt_y_q;

	// take a new beat whenever the result slot is empty or draining now
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	lps_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (in_beat),
		.opcode     (lps_op_t'(s_axis_tuser[0])),
		.start_x    ($signed(s_axis_tdata[C-1:0])),
		.start_y    ($signed(s_axis_tdata[2*C-1:C])),
		.end_x      ($signed(s_axis_tdata[3*C-1:2*C])),
		.end_y      ($signed(s_axis_tdata[4*C-1:3*C])),
		.point_valid(pt_valid),
		.point_x    (pt_x),
		.point_y    (pt_y),
		.point_last (pt_last)
	);

	// result register: load on an input beat, empty once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset; hold it until the next input beat
	always_ff @(posedge clk) begin
		if (in_beat) begin
			pt_valid_q <= pt_valid;
			pt_x_q     <= pt_x;
			pt_y_q     <= pt_y;
			pt_last_q  <= pt_last;
		end
	end

	always_comb begin
		m_axis_tdata          = '0;
		m_axis_tdata[C-1:0]   = pt_x_q;
		m_axis_tdata[2*C-1:C] = pt_y_q;
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tuser[0] = pt_valid_q;
	assign m_axis_tlast    = pt_last_q;

endmodule

// File: hw/rtl/lps_core.sv
// ============================================================================
// lps_core: line state and next-point logic
// Holds the active line and computes the point for the current beat.
// ============================================================================
module lps_core #(
	parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  lps_pkg::lps_op_t             opcode,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         point_valid,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         point_last
);
	import lps_pkg::*;

	localparam int C = COORD_BITS;

	logic                line_active_q;
	logic                x_major_q;
	logic signed [C-1:0] cur_x_q;
	logic signed [C-1:0] cur_y_q;
	logic signed [C-1:0] major_end_q;
	logic        [C:0]   major_delta_q;
	logic        [C:0]   minor_delta_q;
	logic                minor_dir_neg_q;
	logic signed [C+1:0] err_acc_q;

	// load setup
	logic signed [C:0]   dx, dy;
	logic        [C:0]   adx, ady;
	logic                ld_xmaj, ld_swap;
	logic signed [C-1:0] ld_x, ld_y, far_x, far_y, ld_end;
	logic        [C:0]   ld_major, ld_minor;
	logic                ld_dir_neg, ld_last;

	always_comb begin
		dx = {end_x[C-1], end_x} - {start_x[C-1], start_x};
		dy = {end_y[C-1], end_y} - {start_y[C-1], start_y};
		adx = dx[C] ? -dx : dx;
		ady = dy[C] ? -dy : dy;
		ld_xmaj = ady < adx;
		ld_swap = ld_xmaj ? (start_x > end_x) : (start_y > end_y);
		ld_x  = ld_swap ? end_x : start_x;
		ld_y  = ld_swap ? end_y : start_y;
		far_x = ld_swap ? start_x : end_x;
		far_y = ld_swap ? start_y : end_y;
		ld_end     = ld_xmaj ? far_x : far_y;
		ld_major   = ld_xmaj ? adx : ady;
		ld_minor   = ld_xmaj ? ady : adx;
		ld_dir_neg = ld_xmaj ? (far_y < ld_y) : (far_x < ld_x);
		ld_last    = (ld_xmaj ? ld_x : ld_y) == ld_end;
	end

	// step: one error add, one threshold compare, a conditional subtract, increments
	logic signed [C+1:0] err_sum, err_next;
	logic signed [C+2:0] err_dbl;
	logic                hit;
	logic signed [C-1:0] dmin, st_x, st_y;
	logic                st_last;

	always_comb begin
		err_sum = err_acc_q + $signed({1'b0, minor_delta_q});
		err_dbl = {err_sum, 1'b0};
		hit = err_dbl >= $signed({2'b00, major_delta_q});
		err_next = hit ? err_sum - $signed({1'b0, major_delta_q}) : err_sum;
		dmin = minor_dir_neg_q ? '1 : C'(1);
		if (x_major_q) begin
			st_x = cur_x_q + C'(1);
			st_y = hit ? cur_y_q + dmin : cur_y_q;
		end else begin
			st_x = hit ? cur_x_q + dmin : cur_x_q;
			st_y = cur_y_q + C'(1);
		end
		st_last = (x_major_q ? st_x : st_y) == major_end_q;
	end

	always_comb begin
		point_valid = 1'b0;
		point_x     = '0;
		point_y     = '0;
		point_last  = 1'b0;
		case (opcode)
			OP_LOAD: begin
				point_valid = 1'b1;
				point_x     = ld_x;
				point_y     = ld_y;
				point_last  = ld_last;
			end
			OP_STEP: begin
				if (line_active_q) begin
					point_valid = 1'b1;
					point_x     = st_x;
					point_y     = st_y;
					point_last  = st_last;
				end
			end
			default: begin
				point_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q   <= 1'b0;
			x_major_q       <= 1'b0;
			cur_x_q         <= '0;
			cur_y_q         <= '0;
			major_end_q     <= '0;
			major_delta_q   <= '0;
			minor_delta_q   <= '0;
			minor_dir_neg_q <= 1'b0;
			err_acc_q       <= '0;
		end else if (advance) begin
			if (opcode == OP_LOAD) begin
				line_active_q   <= !ld_last;
				x_major_q       <= ld_xmaj;
				cur_x_q         <= ld_x;
				cur_y_q         <= ld_y;
				major_end_q     <= ld_end;
				major_delta_q   <= ld_major;
				minor_delta_q   <= ld_minor;
				minor_dir_neg_q <= ld_dir_neg;
				err_acc_q       <= '0;
			end else if (line_active_q) begin
				line_active_q <= !st_last;
				cur_x_q       <= st_x;
				cur_y_q       <= st_y;
				err_acc_q     <= err_next;
			end
		end
	end

endmodule
